[hdl/wtos_pkg.sv]
// ----------------------------------------------------------------------------
// wtos_pkg
// Shared sizes, codes and types of the windowed time order sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package wtos_pkg;

   // storage and field sizes
   localparam int STORE_DEPTH       = 64;
   localparam int TIME_BITS         = 48;
   localparam int HANDLE_BITS       = 16;
   localparam int TIME_FIELD_BITS   = 48;
   localparam int HANDLE_FIELD_BITS = 16;
   localparam int WINDOW_BITS       = 48;
   localparam int STATUS_BITS       = 2;
   localparam int FILL_BITS         = $clog2(STORE_DEPTH + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_RELEASED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic                   kind;
      logic [TIME_BITS-1:0]   hit_time;
      logic [HANDLE_BITS-1:0] hit_handle;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

`default_nettype wire

[hdl/wtos_front.sv]
// ----------------------------------------------------------------------------
// wtos_front
// Accepts input transfers, decodes them into commands and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wtos_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_operation,
   input  wire logic [wtos_pkg::TIME_FIELD_BITS-1:0]  req_hit_time,
   input  wire logic [wtos_pkg::HANDLE_FIELD_BITS-1:0] req_hit_handle,
   output wtos_pkg::queue_head_type                   head,
   input  wire logic                                  head_take
);
   import wtos_pkg::*;

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   cmd_type              new_cmd;
   logic                 push;
   logic                 pop;

   assign req_stall = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = head_take && (count_ff != '0);

   always_comb begin
      new_cmd.kind       = (req_operation == OP_DRAIN) ? OP_DRAIN : OP_INSERT;
      new_cmd.hit_time   = req_hit_time[TIME_BITS-1:0];
      new_cmd.hit_handle = req_hit_handle[HANDLE_BITS-1:0];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/wtos_back.sv]
// ----------------------------------------------------------------------------
// wtos_back
// Sorted cell chain with its command sequencer: inserts, drains, window
// releases and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtos_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire wtos_pkg::queue_head_type               head,
   output logic                                        head_take,
   input  wire logic                                   csr_valid,
   input  wire logic [wtos_pkg::WINDOW_BITS-1:0]       csr_window,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [wtos_pkg::TIME_FIELD_BITS-1:0]        rsp_out_time,
   output logic [wtos_pkg::HANDLE_FIELD_BITS-1:0]      rsp_out_handle,
   output logic [wtos_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic                                        rsp_last
);
   import wtos_pkg::*;

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_RELEASE = 1'b1;

   logic                   state_ff, state_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [TIME_BITS-1:0]   newest_ff, newest_in;
   logic [WINDOW_BITS-1:0] window_ff;

   logic [TIME_BITS-1:0]   cell_time_ff   [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle_ff [STORE_DEPTH];
   logic [TIME_BITS-1:0]   cell_time_in   [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle_in [STORE_DEPTH];
   logic [TIME_BITS-1:0]   up_time        [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] up_handle      [STORE_DEPTH];
   logic [TIME_BITS-1:0]   dn_time        [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] dn_handle      [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] later;
   logic [STORE_DEPTH-1:0] later_prev;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [TIME_FIELD_BITS-1:0]   rsp_time_ff;
   logic [HANDLE_FIELD_BITS-1:0] rsp_handle_ff;
   logic [STATUS_BITS-1:0]       rsp_status_ff;
   logic                         rsp_last_ff;

   logic                   out_free;
   logic                   full;
   logic                   empty;
   logic [TIME_BITS-1:0]   span0;
   logic [TIME_BITS-1:0]   span1;
   logic                   release_now;
   logic                   release_next;
   logic                   do_insert;
   logic                   do_pop;
   logic                   emit;
   logic [TIME_BITS-1:0]   emit_time;
   logic [HANDLE_BITS-1:0] emit_handle;
   logic [STATUS_BITS-1:0] emit_status;
   logic                   emit_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (fill_ff == FILL_BITS'(STORE_DEPTH));
   assign empty    = (fill_ff == '0);

   // stored times never exceed the newest, so the spans cannot wrap
   assign span0        = newest_ff - cell_time_ff[0];
   assign span1        = newest_ff - cell_time_ff[1];
   assign release_now  = (fill_ff > FILL_BITS'(1)) && (WINDOW_BITS'(span0) > window_ff);
   assign release_next = (fill_ff > FILL_BITS'(2)) && (WINDOW_BITS'(span1) > window_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      head_take   = 1'b0;
      do_insert   = 1'b0;
      do_pop      = 1'b0;
      emit        = 1'b0;
      emit_time   = '0;
      emit_handle = '0;
      emit_status = STATUS_RELEASED;
      emit_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (head.cmd.kind == OP_INSERT && !full) begin
                  head_take = 1'b1;
                  do_insert = 1'b1;
                  state_in  = ST_RELEASE;
               end else if (out_free) begin
                  head_take = 1'b1;
                  emit      = 1'b1;
                  if (head.cmd.kind == OP_INSERT) begin
                     emit_status = STATUS_FULL;
                  end else if (empty) begin
                     emit_status = STATUS_EMPTY;
                  end else begin
                     do_pop      = 1'b1;
                     emit_time   = cell_time_ff[0];
                     emit_handle = cell_handle_ff[0];
                  end
               end
            end
         end
         ST_RELEASE: begin
            if (!release_now) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit        = 1'b1;
               do_pop      = 1'b1;
               emit_time   = cell_time_ff[0];
               emit_handle = cell_handle_ff[0];
               emit_last   = !release_next;
               if (!release_next) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // neighbor views of the cell chain
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         later[i]     = (FILL_BITS'(i) < fill_ff) && (cell_time_ff[i] > head.cmd.hit_time);
         up_time[i]   = cell_time_ff[i];
         up_handle[i] = cell_handle_ff[i];
         dn_time[i]   = cell_time_ff[i];
         dn_handle[i] = cell_handle_ff[i];
      end
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
         up_time[i]   = cell_time_ff[i+1];
         up_handle[i] = cell_handle_ff[i+1];
      end
      for (int i = 1; i < STORE_DEPTH; i++) begin
         dn_time[i]   = cell_time_ff[i-1];
         dn_handle[i] = cell_handle_ff[i-1];
      end
      later_prev = {later[STORE_DEPTH-2:0], 1'b0};
   end

   // each cell shifts up on insert, down on pop, or takes the new hit
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         cell_time_in[i]   = cell_time_ff[i];
         cell_handle_in[i] = cell_handle_ff[i];
         if (do_insert) begin
            if (later_prev[i]) begin
               cell_time_in[i]   = dn_time[i];
               cell_handle_in[i] = dn_handle[i];
            end else if (later[i] || FILL_BITS'(i) == fill_ff) begin
               cell_time_in[i]   = head.cmd.hit_time;
               cell_handle_in[i] = head.cmd.hit_handle;
            end
         end else if (do_pop) begin
            cell_time_in[i]   = up_time[i];
            cell_handle_in[i] = up_handle[i];
         end
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      newest_in = newest_ff;
      if (do_insert) begin
         fill_in = fill_ff + 1'b1;
         if (empty || head.cmd.hit_time >= newest_ff) begin
            newest_in = head.cmd.hit_time;
         end
      end else if (do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            window_ff <= csr_window;
         end
      end
   end

   always_ff @(posedge clock) begin
      newest_ff <= newest_in;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         cell_time_ff[i]   <= cell_time_in[i];
         cell_handle_ff[i] <= cell_handle_in[i];
      end
      if (emit) begin
         rsp_time_ff   <= TIME_FIELD_BITS'(emit_time);
         rsp_handle_ff <= HANDLE_FIELD_BITS'(emit_handle);
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_time   = rsp_time_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

[hdl/windowed_time_order_sorter.sv]
// ----------------------------------------------------------------------------
// windowed_time_order_sorter
// Keeps up to 64 hits in timestamp order and releases the oldest ones once
// the stored span exceeds the programmed window.
// ----------------------------------------------------------------------------
// Input transfers go into a two-entry command queue and are taken while the
// back end is busy; the back end runs one command at a time. An insert places
// the hit in the cell chain, then releases one hit per cycle unless stalled,
// or only checks the window if none is due; a drain or a refused insert gives
// one result. A stalled result register holds the sequencer, so each result
// needs a free slot in it. Equal times keep arrival order. The user must write
// the window register over the csr port only while the block is idle; the
// block does not enforce this. No clearing pass is needed after reset.
`default_nettype none

module windowed_time_order_sorter (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_operation,
   input  wire logic [wtos_pkg::TIME_FIELD_BITS-1:0]    req_hit_time,
   input  wire logic [wtos_pkg::HANDLE_FIELD_BITS-1:0]  req_hit_handle,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [wtos_pkg::TIME_FIELD_BITS-1:0]         rsp_out_time,
   output logic [wtos_pkg::HANDLE_FIELD_BITS-1:0]       rsp_out_handle,
   output logic [wtos_pkg::STATUS_BITS-1:0]             rsp_status,
   output logic                                         rsp_last,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [wtos_pkg::WINDOW_BITS-1:0]        csr_window
);
   import wtos_pkg::*;

   queue_head_type head;
   logic           head_take;

   assign csr_ready = 1'b1;

   wtos_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_hit_time   (req_hit_time),
      .req_hit_handle (req_hit_handle),
      .head           (head),
      .head_take      (head_take)
   );

   wtos_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_take      (head_take),
      .csr_valid      (csr_valid),
      .csr_window     (csr_window),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_time   (rsp_out_time),
      .rsp_out_handle (rsp_out_handle),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

[hdl/wtos_checker.sv]
// ----------------------------------------------------------------------------
// wtos_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wtos_checker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   input  wire logic [wtos_pkg::TIME_FIELD_BITS-1:0]    rsp_out_time,
   input  wire logic [wtos_pkg::HANDLE_FIELD_BITS-1:0]  rsp_out_handle,
   input  wire logic [wtos_pkg::STATUS_BITS-1:0]        rsp_status,
   input  wire logic                                    rsp_last
);
   import wtos_pkg::*;

   logic                       rsp_xfer;
   logic                       open_ff, open_in;
   logic [TIME_FIELD_BITS-1:0] prev_time_ff;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // a result run is open while its previous transfer was not the last one
   assign open_in = rsp_xfer ? !rsp_last : open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         prev_time_ff <= rsp_out_time;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_time)
         && $stable(rsp_out_handle) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RELEASED |->
         rsp_last && rsp_out_time == '0 && rsp_out_handle == '0
         && (rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL))
      else $error("bad status result");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && open_ff |->
         rsp_status == STATUS_RELEASED && rsp_out_time >= prev_time_ff)
      else $error("released hits out of time order");

endmodule

bind windowed_time_order_sorter wtos_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_time   (rsp_out_time),
   .rsp_out_handle (rsp_out_handle),
   .rsp_status     (rsp_status),
   .rsp_last       (rsp_last)
);

`default_nettype wire

[dv/windowed_time_order_sorter_tb.sv]
// ----------------------------------------------------------------------------
// windowed_time_order_sorter_tb
// Self-checking bench for the windowed time order sorter: a short directed
// table, then random insert/drain traffic under several window settings,
// with a store model that predicts every released hit and status.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_time_order_sorter_tb;

   import wtos_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int LATENCY_PAUSE = 16;
   localparam logic [TIME_BITS-1:0]   STAMP_MAX  = '1;
   localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = '1;

   typedef struct packed {
      logic [TIME_BITS-1:0]   stamp;
      logic [HANDLE_BITS-1:0] tag;
   } hit_type;

   typedef struct packed {
      logic [TIME_FIELD_BITS-1:0]   stamp;
      logic [HANDLE_FIELD_BITS-1:0] tag;
      logic [STATUS_BITS-1:0]       status;
      logic                         last;
   } release_type;

   typedef struct packed {
      logic                         op;
      logic [TIME_FIELD_BITS-1:0]   stamp;
      logic [HANDLE_FIELD_BITS-1:0] tag;
      logic                         fixed;
      logic [STATUS_BITS-1:0]       exp_status;
      logic [TIME_FIELD_BITS-1:0]   exp_stamp;
      logic [HANDLE_FIELD_BITS-1:0] exp_tag;
   } stim_row_type;

   logic clock;
   logic reset          = 1'b1;
   logic req_valid      = 1'b0;
   logic req_operation  = OP_INSERT;
   logic [TIME_FIELD_BITS-1:0]   req_hit_time   = '0;
   logic [HANDLE_FIELD_BITS-1:0] req_hit_handle = '0;
   logic rsp_stall      = 1'b0;
   logic csr_valid      = 1'b0;
   logic [WINDOW_BITS-1:0] csr_window = '0;
   logic req_stall;
   logic rsp_valid;
   logic [TIME_FIELD_BITS-1:0]   rsp_out_time;
   logic [HANDLE_FIELD_BITS-1:0] rsp_out_handle;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic rsp_last;
   logic csr_ready;

   // model state
   hit_type     hit_chain[$];
   logic [WINDOW_BITS-1:0] window_setting = '0;
   release_type fresh_releases[$];
   release_type awaited_releases[$];

   int cycle_count    = 0;
   int mismatches     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int empty_drains   = 0;
   int refused_hits   = 0;
   int window_writes  = 0;
   int burst_left     = 0;
   int stall_hold     = 0;

   stim_row_type directed_rows [15];

   windowed_time_order_sorter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_hit_time   (req_hit_time),
      .req_hit_handle (req_hit_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_time   (rsp_out_time),
      .rsp_out_handle (rsp_out_handle),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window     (csr_window)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_releases.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // insert keeps equal stamps in arrival order, then the window trims the head
   function automatic void sort_and_release(input logic op,
                                            input logic [TIME_BITS-1:0] stamp,
                                            input logic [HANDLE_BITS-1:0] tag);
      int          pos;
      hit_type     h;
      release_type r;
      fresh_releases.delete();
      r = '0;
      if (op == OP_DRAIN) begin
         r.last = 1'b1;
         if (hit_chain.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            h = hit_chain[0];
            hit_chain.delete(0);
            r.stamp  = h.stamp;
            r.tag    = h.tag;
            r.status = STATUS_RELEASED;
         end
         fresh_releases.push_back(r);
         return;
      end
      if (hit_chain.size() >= STORE_DEPTH) begin
         r.status = STATUS_FULL;
         r.last   = 1'b1;
         fresh_releases.push_back(r);
         return;
      end
      pos = 0;
      while (pos < hit_chain.size() && hit_chain[pos].stamp <= stamp) pos++;
      h.stamp = stamp;
      h.tag   = tag;
      hit_chain.insert(pos, h);
      while (hit_chain.size() > 1 &&
             (hit_chain[hit_chain.size()-1].stamp - hit_chain[0].stamp) > window_setting) begin
         h = hit_chain[0];
         hit_chain.delete(0);
         r.stamp  = h.stamp;
         r.tag    = h.tag;
         r.status = STATUS_RELEASED;
         r.last   = 1'b0;
         fresh_releases.push_back(r);
      end
      if (fresh_releases.size() > 0) fresh_releases[fresh_releases.size()-1].last = 1'b1;
   endfunction

   function automatic logic [TIME_BITS-1:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TIME_BITS-1:0];
   endfunction

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_hit(input logic op, input logic [TIME_BITS-1:0] stamp,
                           input logic [HANDLE_BITS-1:0] tag, input logic fixed,
                           input release_type fixed_result);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_hit_time   <= stamp;
      req_hit_handle <= tag;
      do @(posedge clock); while (req_stall);
      sort_and_release(op, stamp, tag);
      if (fixed) begin
         fresh_releases.delete();
         fresh_releases.push_back(fixed_result);
      end
      foreach (fresh_releases[i]) awaited_releases.push_back(fresh_releases[i]);
      items_sent++;
   endtask

   // sender goes quiet until every predicted result has come back
   task automatic settle(input int tail);
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_releases.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_BITS-1:0] value);
      settle(LATENCY_PAUSE);
      @(negedge clock);
      csr_valid  <= 1'b1;
      csr_window <= value;
      do @(posedge clock); while (!csr_ready);
      window_setting = value;
      window_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // spread 0 means stamps over the whole range
   task automatic run_mix(input int count, input int drain_pct,
                          input logic [TIME_BITS-1:0] base, input int spread);
      int          k;
      logic        op;
      logic [TIME_BITS-1:0] stamp;
      release_type none;
      none = '0;
      for (k = 0; k < count; k++) begin
         op    = ($urandom_range(1, 100) <= drain_pct) ? OP_DRAIN : OP_INSERT;
         stamp = (spread == 0) ? rand_stamp() : base + TIME_BITS'($urandom_range(0, spread));
         if ($urandom_range(0, 24) == 0) settle(0);
         send_hit(op, stamp, HANDLE_BITS'($urandom()), 1'b0, none);
      end
   endtask

   task automatic drain_store();
      release_type none;
      none = '0;
      while (hit_chain.size() != 0) send_hit(OP_DRAIN, '0, '0, 1'b0, none);
   endtask

   always @(negedge clock) begin : result_stall
      int roll;
      if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            rsp_stall  <= 1'b0;
            stall_hold  = $urandom_range(30, 120);
         end else if (roll < 20) begin
            rsp_stall  <= 1'b1;
            stall_hold  = $urandom_range(0, 2);
         end else if (roll < 22) begin
            rsp_stall  <= 1'b1;
            stall_hold  = $urandom_range(10, 40);
         end else begin
            rsp_stall  <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      release_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_status == STATUS_EMPTY) empty_drains++;
         if (rsp_status == STATUS_FULL)  refused_hits++;
         if (awaited_releases.size() == 0) begin
            $error("result with nothing expected: time %h handle %h status %0d last %0b",
                   rsp_out_time, rsp_out_handle, rsp_status, rsp_last);
            mismatches++;
         end else begin
            want = awaited_releases[0];
            awaited_releases.delete(0);
            results_seen++;
            if (rsp_out_time !== want.stamp) begin
               $error("out_time expected %h actual %h", want.stamp, rsp_out_time);
               mismatches++;
            end
            if (rsp_out_handle !== want.tag) begin
               $error("out_handle expected %h actual %h", want.tag, rsp_out_handle);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      release_type fixed_result;
      int          k;
      release_type none;
      none = '0;

      // window is still at its reset value of zero for this table
      directed_rows = '{
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b1, STATUS_EMPTY,    48'd0,     16'h0000},
         '{OP_INSERT, 48'd0,     16'h0000, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b1, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b1, STATUS_EMPTY,    48'd0,     16'h0000},
         '{OP_INSERT, STAMP_MAX, 16'hffff, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, STAMP_MAX, 16'h1234, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, 48'd0,     16'h0001, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b1, STATUS_RELEASED, STAMP_MAX, 16'hffff},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, 48'd1000,  16'haaaa, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, 48'd999,   16'h5555, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, 48'd1000,  16'h0007, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_INSERT, 48'd2000,  16'h0008, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b0, STATUS_RELEASED, 48'd0,     16'h0000},
         '{OP_DRAIN,  48'd0,     16'h0000, 1'b1, STATUS_EMPTY,    48'd0,     16'h0000}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < 15; k++) begin
         fixed_result.stamp  = directed_rows[k].exp_stamp;
         fixed_result.tag    = directed_rows[k].exp_tag;
         fixed_result.status = directed_rows[k].exp_status;
         fixed_result.last   = 1'b1;
         send_hit(directed_rows[k].op, directed_rows[k].stamp, directed_rows[k].tag,
                  directed_rows[k].fixed, fixed_result);
      end

      // narrow window, clustered stamps
      write_window(WINDOW_BITS'($urandom_range(1, 64)));
      run_mix(8, 20, rand_stamp() >> 1, 100);

      // arbitrary window and stamps
      write_window(rand_stamp());
      run_mix(8, 30, '0, 0);
      drain_store();

      // widest window: fill the store, one refused insert, free one slot
      write_window(WINDOW_MAX);
      run_mix(STORE_DEPTH + 1, 0, '0, 0);
      send_hit(OP_DRAIN, '0, '0, 1'b0, none);

      // zero window: the newest possible stamp flushes everything else
      write_window('0);
      send_hit(OP_INSERT, STAMP_MAX, HANDLE_BITS'($urandom()), 1'b0, none);
      run_mix(6, 25, rand_stamp() >> 1, 20);

      write_window(rand_stamp() >> $urandom_range(8, 40));
      run_mix(6, 30, rand_stamp() >> 1, 1 << 20);
      drain_store();
      send_hit(OP_DRAIN, '0, '0, 1'b0, none);

      settle(LATENCY_PAUSE * 2);

      $display("sorter run: %0d transfers in, %0d results compared, %0d window writes",
               items_sent, results_seen, window_writes);
      $display("seen %0d empty drains and %0d refused inserts; a full-store flush included",
               empty_drains, refused_hits);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
